// ===== design/four_register_alu_executor_core_assert.svh =====
// Assertion macros for the four-register ALU executor.
// Included by the top level; no other dependencies.
`ifndef FOUR_REGISTER_ALU_EXECUTOR_CORE_ASSERT_SVH
`define FOUR_REGISTER_ALU_EXECUTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FRA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FRA_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRA_ASSERT(label, clk, rst, prop, msg)
`define FRA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== design/fra_pkg.sv =====
// Shared types and codes for the four-register ALU executor.
// No dependencies.
package fra_pkg;
  typedef enum logic [2:0] {
    OP_DIGIT = 3'd0, OP_ADD = 3'd1, OP_MUL = 3'd2,
    OP_DIV = 3'd3, OP_MOD = 3'd4, OP_EQL = 3'd5
  } op_t;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_BADMOD = 2'd2, ST_SKIP = 2'd3
  } status_t;
  typedef enum logic [1:0] {
    BK_IDLE, BK_MUL, BK_DIV, BK_DONE
  } bk_state_t;
  localparam logic [1:0] REG_Z = 2'd3;
endpackage

// ===== design/fra_if.sv =====
// Valid/ready channel carrying a generic payload.
// Depends on nothing; payload type is a parameter.
interface fra_if #(parameter type PAYLOAD_T = logic) ();
  logic     valid;
  logic     ready;
  PAYLOAD_T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/fra_front.sv =====
// Front end: accepts instruction beats into a two-entry queue.
// Depends on fra_pkg.
module fra_front import fra_pkg::*; #(
  parameter int W = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         q_valid,
  input  logic         q_pop,
  output logic [W-1:0] q_data
);
  logic [W-1:0] mem [2];
  logic         wptr, rptr;
  logic [1:0]   count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_data   = mem[rptr];

  // Queue pointers and storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, q_pop};
    end
    if (in_valid && in_ready) mem[wptr] <= in_data;
  end
endmodule

// ===== design/fra_back.sv =====
// Back end: register file, half-width multiply and restoring divider, result register.
// Depends on fra_pkg.
module fra_back import fra_pkg::*; #(
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  logic [2:0]    op,
  input  logic [1:0]    dest_reg,
  input  logic          src_is_reg,
  input  logic [1:0]    src_reg,
  input  logic [63:0]   src_imm,
  input  logic [3:0]    digit,
  input  logic          first,
  input  logic          last,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic [63:0]   dest_value,
  output logic [63:0]   z_value,
  output logic          done_res,
  output logic          accepted
);
  localparam int CW = $clog2(DW + 1);
  localparam int HW = DW / 2;

  logic [DW-1:0] regs [4];
  logic          fault;
  bk_state_t     state, state_next;
  logic [DW-1:0] a, b, qa, qb, rem, mb, p0, p1, p2;
  logic [CW-1:0] cnt;
  logic          negq, is_mod;
  logic [1:0]    mstep;

  // Operand fetch honors the program-start clear.
  logic [DW-1:0] ra, rb;
  assign ra = first ? '0 : regs[dest_reg];
  assign rb = src_is_reg ? (first ? '0 : regs[src_reg]) : src_imm[DW-1:0];
  logic fault_eff;
  assign fault_eff = first ? 1'b0 : fault;

  // The partial remainder stays below the divisor, so its top bit is always clear.
  logic [DW:0] trial;
  assign trial = {1'b0, rem[DW-2:0], qa[DW-1]} - {1'b0, qb};

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    unique case (state)
      BK_IDLE: if (q_valid && !out_valid) begin
        if (fault_eff || !(op == OP_MUL || op == OP_DIV || op == OP_MOD))
          state_next = BK_IDLE;
        else if (op == OP_MUL) state_next = BK_MUL;
        else if ((op == OP_DIV && rb == '0) ||
                 (op == OP_MOD && (ra[DW-1] || rb[DW-1] || rb == '0)))
          state_next = BK_IDLE;
        else state_next = BK_DIV;
        q_pop = (state_next == BK_IDLE);
      end
      BK_MUL: if (mstep == 2'd3) state_next = BK_DONE;
      BK_DIV: if (cnt == CW'(DW)) state_next = BK_DONE;
      BK_DONE: begin state_next = BK_IDLE; q_pop = 1'b1; end
      default: state_next = BK_IDLE;
    endcase
  end

  function automatic logic [63:0] sx(input logic [DW-1:0] v);
    return 64'(signed'(v));
  endfunction

  // Commit a result into the register file and the output register.
  task automatic commit(input logic [1:0] st, input logic wr, input logic [DW-1:0] r);
    logic [DW-1:0] nz;
    logic          nf;
    nz = (wr && dest_reg == REG_Z) ? r : (first ? '0 : regs[REG_Z]);
    nf = fault_eff || (st != ST_OK && st != ST_SKIP) || st == ST_SKIP;
    for (int i = 0; i < 4; i++)
      regs[i] <= (wr && dest_reg == 2'(i)) ? r : (first ? '0 : regs[i]);
    fault      <= nf;
    out_valid  <= 1'b1;
    status     <= st;
    dest_value <= sx(wr ? r : ra);
    z_value    <= sx(nz);
    done_res   <= last;
    accepted   <= last && !nf && nz == '0;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE; out_valid <= 1'b0; fault <= 1'b0;
      for (int i = 0; i < 4; i++) regs[i] <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        BK_IDLE: if (q_valid && !out_valid) begin
          a <= ra; b <= rb;
          is_mod <= (op == OP_MOD);
          negq <= ra[DW-1] ^ rb[DW-1];
          qa <= ra[DW-1] ? -ra : ra;
          qb <= rb[DW-1] ? -rb : rb;
          rem <= '0; cnt <= '0; mstep <= 2'd0;
          if (fault_eff) commit(ST_SKIP, 1'b0, ra);
          else if (state_next == BK_IDLE) begin
            case (op)
              OP_DIGIT: commit(ST_OK, 1'b1, DW'(digit));
              OP_ADD:   commit(ST_OK, 1'b1, ra + rb);
              OP_EQL:   commit(ST_OK, 1'b1, DW'(ra == rb));
              OP_DIV:   commit(ST_DIV0, 1'b0, ra);
              OP_MOD:   commit(ST_BADMOD, 1'b0, ra);
              default:  commit(ST_OK, 1'b0, ra);
            endcase
          end
        end
        BK_MUL: begin
          // Three half-width partial products, one per cycle, then their sum; the step count
          // holds at its last value so the done state knows a product is ready.
          if (mstep != 2'd3) mstep <= mstep + 2'd1;
          unique case (mstep)
            2'd0: p0 <= DW'(a[HW-1:0] * b[HW-1:0]);
            2'd1: p1 <= DW'(a[HW-1:0] * b[DW-1:HW]) << HW;
            2'd2: p2 <= DW'(a[DW-1:HW] * b[HW-1:0]) << HW;
            default: mb <= p0 + p1 + p2;
          endcase
        end
        BK_DIV: if (cnt != CW'(DW)) begin
          // One quotient bit per cycle.
          cnt <= cnt + CW'(1);
          qa  <= {qa[DW-2:0], ~trial[DW]};
          rem <= trial[DW] ? {rem[DW-2:0], qa[DW-1]} : trial[DW-1:0];
        end
        BK_DONE: begin
          if (mstep == 2'd3) commit(ST_OK, 1'b1, mb);
          else commit(ST_OK, 1'b1, is_mod ? rem : (negq ? -qa : qa));
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== design/four_register_alu_executor_core.sv =====
// Top level of the four-register ALU executor.
// Depends on fra_pkg, fra_if, fra_front, fra_back and the assertion header.
// One result beat per instruction beat, in order. An accepted beat waits in a
// two-entry queue until the back end, idle with a free result register, takes it.
// Digit, add, equal, unused opcodes, skipped and faulting instructions commit
// their result from the idle state; multiply runs four steps in the half-width
// multiplier plus a commit; divide and modulo run the restoring divider, one
// quotient bit per cycle, then commit. The back end starts the next instruction
// only once the result register has been taken.
`include "four_register_alu_executor_core_assert.svh"
module four_register_alu_executor_core import fra_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input logic clk,
  input logic rst,
  fra_if.sink   in_ch,
  fra_if.source out_ch
);
  localparam int IW = 3 + 2 + 1 + 2 + 64 + 4 + 1 + 1;
  logic [IW-1:0] qd;
  logic q_valid, q_pop;

  fra_front #(.W(IW)) u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data({in_ch.data.op, in_ch.data.dest_reg, in_ch.data.src_is_reg,
              in_ch.data.src_reg, in_ch.data.src_imm, in_ch.data.digit,
              in_ch.data.first, in_ch.data.last}),
    .q_valid, .q_pop, .q_data(qd)
  );

  fra_back #(.DW(DATA_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_pop,
    .op(qd[77:75]), .dest_reg(qd[74:73]), .src_is_reg(qd[72]),
    .src_reg(qd[71:70]), .src_imm(qd[69:6]), .digit(qd[5:2]),
    .first(qd[1]), .last(qd[0]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.data.status), .dest_value(out_ch.data.dest_value),
    .z_value(out_ch.data.z_value), .done_res(out_ch.data.done_res),
    .accepted(out_ch.data.accepted)
  );

  // An accepted flag on a valid result beat.
  logic res_acc;
  assign res_acc = out_ch.valid && out_ch.data.accepted;

  `FRA_ASSERT(a_pop_needs_item, clk, rst, q_pop |-> q_valid, "pop of empty queue")
  `FRA_ASSERT(a_acc_only_done, clk, rst, res_acc |-> out_ch.data.done_res, "accepted without done")
endmodule
